// ===== rtl/srre_pkg.sv =====
// Shared constants, types and codes of the skip-run record encoder.
`default_nettype none
package srre_pkg;

    localparam int OUTCOME_W  = 2;
    localparam int MEX_W      = 5;
    localparam int REM_W      = 8;
    localparam int COUNT_W    = 32;
    localparam int LVL_W      = $clog2(COUNT_W + 1);
    localparam int CHUNK_W    = 33;
    localparam int LEN_W      = 6;
    localparam int BODY_W     = OUTCOME_W + MEX_W + REM_W;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 2;
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_SKIP_MODE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_UNDECIDED = CFG_IDX_W'(1);

    typedef struct packed {
        logic               flush;
        logic               flush_end;
        logic               rec;
        logic               last;
        logic [LVL_W-1:0]   k;
        logic [COUNT_W-1:0] rem;
        logic [COUNT_W-1:0] mask;
        logic [BODY_W-1:0]  body;
        logic [LEN_W-1:0]   body_len;
    } t_job;

    typedef enum logic [2:0] {
        PH_PRE = 3'b001,
        PH_SUF = 3'b010,
        PH_REC = 3'b100
    } t_phase;

endpackage
`default_nettype wire

// ===== rtl/srre_rec_if.sv =====
// Input record channel.
`default_nettype none
interface srre_rec_if;
    logic                           valid;
    logic                           ready;
    logic [srre_pkg::OUTCOME_W-1:0] outcome;
    logic [srre_pkg::MEX_W-1:0]     mex;
    logic [srre_pkg::REM_W-1:0]     remoteness;
    logic                           last_record;

    modport source (output valid, outcome, mex, remoteness, last_record, input ready);
    modport sink   (input valid, outcome, mex, remoteness, last_record, output ready);
endinterface
`default_nettype wire

// ===== rtl/srre_chunk_if.sv =====
// Output code chunk channel.
`default_nettype none
interface srre_chunk_if;
    logic                         valid;
    logic                         ready;
    logic [srre_pkg::CHUNK_W-1:0] chunk_bits;
    logic [srre_pkg::LEN_W-1:0]   chunk_len;
    logic                         stream_end;

    modport source (output valid, chunk_bits, chunk_len, stream_end, input ready);
    modport sink   (input valid, chunk_bits, chunk_len, stream_end, output ready);
endinterface
`default_nettype wire

// ===== rtl/srre_front.sv =====
// Front end: configuration, record classification and run tracking.
`default_nettype none
module srre_front (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    srre_rec_if.sink                             i_rec,
    input  wire logic                            i_cfg_we,
    input  wire logic [srre_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [srre_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                            i_q_full,
    output logic                                 o_push,
    output srre_pkg::t_job                       o_job
);

    logic                           r_skip_mode;
    logic [srre_pkg::OUTCOME_W-1:0] r_undecided;
    logic [srre_pkg::LVL_W-1:0]     r_lvl, n_lvl, inc_lvl;
    logic [srre_pkg::COUNT_W-1:0]   r_rem, n_rem, inc_rem;
    logic [srre_pkg::COUNT_W-1:0]   r_mask, n_mask, inc_mask;
    logic                           fire;
    logic                           is_skip;

    assign i_rec.ready = !i_q_full;
    assign fire        = i_rec.valid && !i_q_full;
    assign is_skip     = r_skip_mode && (i_rec.outcome == r_undecided);

    always_comb begin
        inc_lvl  = r_lvl;
        inc_rem  = r_rem;
        inc_mask = r_mask;
        if (r_lvl != srre_pkg::LVL_W'(srre_pkg::COUNT_W)) begin
            if (r_rem == r_mask) begin
                inc_lvl  = r_lvl + 1'b1;
                inc_rem  = '0;
                inc_mask = {r_mask[srre_pkg::COUNT_W-2:0], 1'b1};
            end else begin
                inc_rem = r_rem + 1'b1;
            end
        end
    end

    always_comb begin
        n_lvl          = r_lvl;
        n_rem          = r_rem;
        n_mask         = r_mask;
        o_push         = 1'b0;
        o_job.flush    = 1'b1;
        o_job.flush_end = 1'b0;
        o_job.rec      = 1'b0;
        o_job.last     = i_rec.last_record;
        o_job.k        = r_lvl;
        o_job.rem      = r_rem;
        o_job.mask     = r_mask;
        o_job.body     = {i_rec.outcome, i_rec.mex, i_rec.remoteness};
        o_job.body_len = r_skip_mode ? srre_pkg::LEN_W'(srre_pkg::BODY_W + 1)
                                     : srre_pkg::LEN_W'(srre_pkg::BODY_W);
        if (fire) begin
            if (is_skip) begin
                if (i_rec.last_record) begin
                    o_push          = 1'b1;
                    o_job.flush_end = 1'b1;
                    o_job.k         = inc_lvl;
                    o_job.rem       = inc_rem;
                    o_job.mask      = inc_mask;
                    n_lvl           = '0;
                    n_rem           = '0;
                    n_mask          = '0;
                end else begin
                    n_lvl  = inc_lvl;
                    n_rem  = inc_rem;
                    n_mask = inc_mask;
                end
            end else begin
                o_push      = 1'b1;
                o_job.flush = (r_lvl != '0);
                o_job.rec   = 1'b1;
                n_lvl       = '0;
                n_rem       = '0;
                n_mask      = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip_mode <= 1'b1;
            r_undecided <= '1;
            r_lvl       <= '0;
            r_rem       <= '0;
            r_mask      <= '0;
        end else begin
            r_lvl  <= n_lvl;
            r_rem  <= n_rem;
            r_mask <= n_mask;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    srre_pkg::CFG_SKIP_MODE: r_skip_mode <= i_cfg_data[0];
                    srre_pkg::CFG_UNDECIDED: r_undecided <= i_cfg_data[srre_pkg::OUTCOME_W-1:0];
                    default: ;
                endcase
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/srre_queue.sv =====
// Short job queue between front end and back end.
`default_nettype none
module srre_queue (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_push,
    input  wire srre_pkg::t_job               i_job,
    input  wire logic                         i_pop,
    output logic                              o_full,
    output logic                              o_valid,
    output srre_pkg::t_job                    o_head,
    output logic [srre_pkg::QCNT_W-1:0]       o_count
);

    srre_pkg::t_job                r_mem [srre_pkg::QDEPTH];
    logic [srre_pkg::QPTR_W-1:0]   r_wr, r_rd;
    logic [srre_pkg::QCNT_W-1:0]   r_cnt;
    logic                          do_push, do_pop;

    function automatic logic [srre_pkg::QPTR_W-1:0] bump(input logic [srre_pkg::QPTR_W-1:0] p);
        if (p == srre_pkg::QPTR_W'(srre_pkg::QDEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    assign o_full  = (r_cnt == srre_pkg::QCNT_W'(srre_pkg::QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd];
    assign o_count = r_cnt;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= bump(r_wr);
            end
            if (do_pop) begin
                r_rd <= bump(r_rd);
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== rtl/srre_back.sv =====
// Back end: splits each job into prefix, suffix and record beats.
`default_nettype none
module srre_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_q_valid,
    input  wire srre_pkg::t_job i_job,
    output logic                o_pop,
    srre_chunk_if.source        o_chunk
);

    srre_pkg::t_phase              r_phase, n_phase, cur, nxt;
    logic                          r_out_valid;
    logic [srre_pkg::CHUNK_W-1:0]  r_bits, beat_bits;
    logic [srre_pkg::LEN_W-1:0]    r_len, beat_len;
    logic                          r_end, beat_end;
    logic                          done;
    logic                          slot_free;
    logic                          take;

    assign slot_free = !r_out_valid || o_chunk.ready;
    assign take      = i_q_valid && slot_free;

    always_comb begin
        cur = r_phase;
        if (r_phase == srre_pkg::PH_PRE && !i_job.flush) begin
            cur = srre_pkg::PH_REC;
        end
        case (cur)
            srre_pkg::PH_PRE: begin
                beat_bits = srre_pkg::CHUNK_W'({i_job.mask, 1'b0});
                beat_len  = srre_pkg::LEN_W'(i_job.k) + srre_pkg::LEN_W'(1);
                beat_end  = 1'b0;
                done      = 1'b0;
                nxt       = srre_pkg::PH_SUF;
            end
            srre_pkg::PH_SUF: begin
                beat_bits = srre_pkg::CHUNK_W'(i_job.rem);
                beat_len  = srre_pkg::LEN_W'(i_job.k);
                beat_end  = i_job.flush_end;
                done      = !i_job.rec;
                nxt       = i_job.rec ? srre_pkg::PH_REC : srre_pkg::PH_PRE;
            end
            srre_pkg::PH_REC: begin
                beat_bits = srre_pkg::CHUNK_W'(i_job.body);
                beat_len  = i_job.body_len;
                beat_end  = i_job.last;
                done      = 1'b1;
                nxt       = srre_pkg::PH_PRE;
            end
            default: begin
                beat_bits = '0;
                beat_len  = '0;
                beat_end  = 1'b0;
                done      = 1'b1;
                nxt       = srre_pkg::PH_PRE;
            end
        endcase
        o_pop   = take && done;
        n_phase = take ? nxt : r_phase;
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_bits <= beat_bits;
            r_len  <= beat_len;
            r_end  <= beat_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= srre_pkg::PH_PRE;
            r_out_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            if (slot_free) begin
                r_out_valid <= i_q_valid;
            end
        end
    end

    assign o_chunk.valid      = r_out_valid;
    assign o_chunk.chunk_bits = r_bits;
    assign o_chunk.chunk_len  = r_len;
    assign o_chunk.stream_end = r_end;

endmodule
`default_nettype wire

// ===== rtl/skip_run_record_encoder.sv =====
// Skip-run record encoder top level: front end, job queue and back end.
// A record's first beat passes the job queue and then the back end's output register.
// The input takes one record a cycle while the job queue is not full; each record
// takes 0 to 3 output beats, sent one a cycle while the output is ready.
// Reset: synchronous, active low; clears run count and queue, sets skip mode on and
// the undecided code to 3.
`default_nettype none
module skip_run_record_encoder (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    srre_rec_if.sink                             i_rec,
    srre_chunk_if.source                         o_chunk,
    input  wire logic                            i_cfg_we,
    input  wire logic [srre_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [srre_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    logic                          push, pop, q_full, q_valid;
    srre_pkg::t_job                push_job, head_job;
    logic [srre_pkg::QCNT_W-1:0]   q_count;

    srre_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rec      (i_rec),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_job      (push_job)
    );

    srre_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (head_job),
        .o_count (q_count)
    );

    srre_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_job     (head_job),
        .o_pop     (pop),
        .o_chunk   (o_chunk)
    );

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_count <= srre_pkg::QCNT_W'(srre_pkg::QDEPTH))
        else $error("job queue count out of range");

    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> q_valid)
        else $error("pop from empty job queue");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_full)
        else $error("push into full job queue");

    a_beat_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_chunk.valid |-> (o_chunk.chunk_len != '0))
        else $error("empty chunk on output");

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// Testbench of the skip-run record encoder: directed and random record streams, checked per chunk.
`timescale 1ns / 1ps
module tb_top;

    typedef struct packed {
        logic [srre_pkg::OUTCOME_W-1:0] outcome;
        logic [srre_pkg::MEX_W-1:0]     mex;
        logic [srre_pkg::REM_W-1:0]     remoteness;
        logic                           last_record;
    } t_record;

    typedef struct packed {
        logic [srre_pkg::CHUNK_W-1:0] bits;
        logic [srre_pkg::LEN_W-1:0]   len;
        logic                         stream_end;
    } t_chunk;

    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 4;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [srre_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [srre_pkg::CFG_DATA_W-1:0] i_cfg_data;

    srre_rec_if   rec_bus ();
    srre_chunk_if chunk_bus ();

    skip_run_record_encoder uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rec      (rec_bus),
        .o_chunk    (chunk_bus),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    logic                           cfg_skip_mode;
    logic [srre_pkg::OUTCOME_W-1:0] cfg_undecided;
    logic [srre_pkg::COUNT_W-1:0]   run_len;
    t_chunk                         expected_chunks[$];
    int                             errors = 0;
    bit                             steady = 1'b0;

    function automatic void push_chunk(logic [63:0] bits, logic [63:0] len, logic stream_end);
        t_chunk c;
        c.bits       = bits[srre_pkg::CHUNK_W-1:0];
        c.len        = len[srre_pkg::LEN_W-1:0];
        c.stream_end = stream_end;
        expected_chunks.push_back(c);
    endfunction

    // Emit the pending run as an order-k code: prefix of k ones and a zero, then k suffix bits.
    function automatic void flush_run(logic stream_end);
        logic [63:0] limit;
        logic [63:0] ones;
        int unsigned k;
        k     = 1;
        limit = 64'd4;
        while (64'(run_len) > limit - 64'd2 && k < 62) begin
            limit = limit << 1;
            k++;
        end
        ones = (64'd1 << k) - 64'd1;
        push_chunk(ones << 1, 64'(k + 1), 1'b0);
        push_chunk((64'(run_len) - ones) & ones, 64'(k), stream_end);
        run_len = '0;
    endfunction

    function automatic void encode_record(t_record r);
        logic [63:0] body;
        logic [63:0] body_len;
        body     = 64'({r.outcome, r.mex, r.remoteness});
        body_len = 64'(srre_pkg::BODY_W);
        if (cfg_skip_mode && r.outcome == cfg_undecided) begin
            if (run_len != '1) begin
                run_len = run_len + 1'b1;
            end
            if (r.last_record) begin
                flush_run(1'b1);
            end
        end else begin
            if (run_len != '0) begin
                flush_run(1'b0);
            end
            if (cfg_skip_mode) begin
                body_len = body_len + 64'd1;
            end
            push_chunk(body, body_len, r.last_record);
        end
    endfunction

    function automatic t_record make_rec(int unsigned outcome, int unsigned mex,
                                         int unsigned rem, bit last);
        t_record r;
        r.outcome     = srre_pkg::OUTCOME_W'(outcome);
        r.mex         = srre_pkg::MEX_W'(mex);
        r.remoteness  = srre_pkg::REM_W'(rem);
        r.last_record = last;
        return r;
    endfunction

    function automatic t_record random_record(bit empty, int unsigned last_odds);
        t_record r;
        r.outcome = empty ? cfg_undecided : srre_pkg::OUTCOME_W'($urandom_range(0, 3));
        if (!empty && cfg_skip_mode && r.outcome == cfg_undecided) begin
            r.outcome = r.outcome + srre_pkg::OUTCOME_W'($urandom_range(1, 3));
        end
        r.mex         = srre_pkg::MEX_W'($urandom_range(0, 31));
        r.remoteness  = srre_pkg::REM_W'($urandom_range(0, 255));
        r.last_record = ($urandom_range(1, last_odds) == 1);
        return r;
    endfunction

    function automatic int unsigned pick_run_len();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 30) begin
            return 0;
        end else if (roll < 80) begin
            return $urandom_range(1, 6);
        end else if (roll < 96) begin
            return $urandom_range(7, 40);
        end else begin
            return $urandom_range(41, 300);
        end
    endfunction

    // Valid stays high after the accepting edge; callers that stop sending lower it.
    task automatic send_record(input t_record r);
        while (!steady && $urandom_range(0, 99) < 32) begin
            rec_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        rec_bus.valid       <= 1'b1;
        rec_bus.outcome     <= r.outcome;
        rec_bus.mex         <= r.mex;
        rec_bus.remoteness  <= r.remoteness;
        rec_bus.last_record <= r.last_record;
        @(posedge i_clk);
        while (rec_bus.ready !== 1'b1) begin
            @(posedge i_clk);
        end
        encode_record(r);
    endtask

    task automatic pause_until_drained();
        rec_bus.valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (expected_chunks.size() != 0);
    endtask

    task automatic settle();
        pause_until_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_config(input logic mode, input logic [srre_pkg::OUTCOME_W-1:0] code);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= srre_pkg::CFG_SKIP_MODE;
        i_cfg_data <= srre_pkg::CFG_DATA_W'(mode);
        @(posedge i_clk);
        cfg_skip_mode = mode;
        i_cfg_idx  <= srre_pkg::CFG_UNDECIDED;
        i_cfg_data <= srre_pkg::CFG_DATA_W'(code);
        @(posedge i_clk);
        cfg_undecided = code;
        i_cfg_we <= 1'b0;
    endtask

    // Mostly runs of empty records closed by a decided one; some records are plain noise.
    task automatic run_streams(input int unsigned budget);
        int unsigned sent;
        int unsigned run;
        int unsigned i;
        bit          paused;
        t_record     r;
        sent   = 0;
        paused = 1'b0;
        while (sent < budget) begin
            if (!paused && sent >= budget / 2) begin
                pause_until_drained();
                paused = 1'b1;
            end
            if ($urandom_range(0, 9) == 0) begin
                r = random_record(1'b0, 2);
                r.outcome = srre_pkg::OUTCOME_W'($urandom_range(0, 3));
                send_record(r);
                sent++;
            end else begin
                run = pick_run_len();
                if (run > budget - sent - 1) begin
                    run = budget - sent - 1;
                end
                for (i = 0; i < run; i++) begin
                    send_record(random_record(1'b1, 40));
                end
                send_record(random_record(1'b0, 6));
                sent += run + 1;
            end
        end
    endtask

    task automatic test_reset_defaults();
        send_record(make_rec(0, 0, 0, 0));
        send_record(make_rec(2, 31, 255, 0));
        send_record(make_rec(3, 0, 0, 0));
        send_record(make_rec(1, 5, 170, 0));
        send_record(make_rec(3, 31, 255, 0));
        send_record(make_rec(3, 31, 255, 0));
        send_record(make_rec(0, 16, 1, 0));
        repeat (3) send_record(make_rec(3, 10, 85, 0));
        send_record(make_rec(2, 1, 128, 1));
        repeat (6) send_record(make_rec(3, 21, 42, 0));
        send_record(make_rec(3, 31, 255, 1));
    endtask

    task automatic test_plain_mode();
        settle();
        write_config(1'b0, srre_pkg::OUTCOME_W'(0));
        send_record(make_rec(0, 0, 0, 0));
        send_record(make_rec(3, 31, 255, 0));
        send_record(make_rec(1, 7, 99, 1));
    endtask

    task automatic test_mode_switch();
        settle();
        write_config(1'b1, srre_pkg::OUTCOME_W'(0));
        send_record(make_rec(0, 3, 200, 0));
        send_record(make_rec(0, 30, 17, 0));
        settle();
        write_config(1'b0, srre_pkg::OUTCOME_W'(0));
        send_record(make_rec(1, 12, 77, 1));
    endtask

    task automatic test_random_settings();
        int p;
        for (p = 0; p < 6; p++) begin
            settle();
            case (p)
                0: begin
                    write_config(1'b1, srre_pkg::OUTCOME_W'(0));
                end
                1: begin
                    write_config(1'b1, srre_pkg::OUTCOME_W'(3));
                end
                2: begin
                    write_config(1'b0, srre_pkg::OUTCOME_W'($urandom_range(0, 3)));
                end
                default: begin
                    write_config($urandom_range(0, 3) != 0,
                                 srre_pkg::OUTCOME_W'($urandom_range(0, 3)));
                end
            endcase
            run_streams(56);
        end
    endtask

    task automatic test_steady_stream();
        settle();
        write_config(1'b1, srre_pkg::OUTCOME_W'($urandom_range(0, 3)));
        steady = 1'b1;
        run_streams(120);
        settle();
        steady = 1'b0;
    endtask

    always @(posedge i_clk) begin
        chunk_bus.ready <= steady || ($urandom_range(0, 99) >= 32);
    end

    always @(posedge i_clk) begin : chunk_checker
        t_chunk want;
        if (i_rst_n === 1'b1 && chunk_bus.valid === 1'b1 && chunk_bus.ready === 1'b1) begin
            if (expected_chunks.size() == 0) begin
                errors++;
                $display("%0t: unexpected beat: expected none, got bits %h len %0d end %0b",
                         $time, chunk_bus.chunk_bits, chunk_bus.chunk_len, chunk_bus.stream_end);
            end else begin
                want = expected_chunks.pop_front();
                if (chunk_bus.chunk_bits !== want.bits) begin
                    errors++;
                    $display("%0t: chunk_bits expected %h got %h",
                             $time, want.bits, chunk_bus.chunk_bits);
                end
                if (chunk_bus.chunk_len !== want.len) begin
                    errors++;
                    $display("%0t: chunk_len expected %0d got %0d",
                             $time, want.len, chunk_bus.chunk_len);
                end
                if (chunk_bus.stream_end !== want.stream_end) begin
                    errors++;
                    $display("%0t: stream_end expected %0b got %0b",
                             $time, want.stream_end, chunk_bus.stream_end);
                end
            end
        end
    end

    initial begin : watchdog
        int stalled;
        stalled = 0;
        while (stalled < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((rec_bus.valid === 1'b1 && rec_bus.ready === 1'b1) ||
                (chunk_bus.valid === 1'b1 && chunk_bus.ready === 1'b1)) begin
                stalled = 0;
            end else begin
                stalled++;
            end
        end
        $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
        $display("** skip_run_record_encoder: FAILED **");
        $finish;
    end

    initial begin
        i_rst_n               = 1'b0;
        i_cfg_we              = 1'b0;
        i_cfg_idx             = '0;
        i_cfg_data            = '0;
        rec_bus.valid         = 1'b0;
        rec_bus.outcome       = '0;
        rec_bus.mex           = '0;
        rec_bus.remoteness    = '0;
        rec_bus.last_record   = 1'b0;
        chunk_bus.ready       = 1'b0;
        cfg_skip_mode         = 1'b1;
        cfg_undecided         = srre_pkg::OUTCOME_W'(3);
        run_len               = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_plain_mode();
        test_mode_switch();
        test_random_settings();
        test_steady_stream();

        pause_until_drained();
        repeat (8) @(posedge i_clk);
        if (expected_chunks.size() != 0) begin
            errors += expected_chunks.size();
            $display("%0t: %0d expected beats never arrived", $time, expected_chunks.size());
        end
        if (errors == 0) begin
            $display("** skip_run_record_encoder: PASSED **");
        end else begin
            $display("** skip_run_record_encoder: FAILED **");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/srre_pkg.sv
rtl/srre_rec_if.sv
rtl/srre_chunk_if.sv
rtl/srre_front.sv
rtl/srre_queue.sv
rtl/srre_back.sv
rtl/skip_run_record_encoder.sv
tb/tb_top.sv
